// ----- src/bloom_wisard_h3_discriminator_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the Bloom WiSARD H3 discriminator
// Short forms for the clocked implication checks used in the RTL.
// ---------------------------------------------------------------------------
`ifndef BLOOM_WISARD_H3_DISCRIMINATOR_MACROS_SVH
`define BLOOM_WISARD_H3_DISCRIMINATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BWH_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define BWH_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ----- src/bwh_pkg.sv -----
// ---------------------------------------------------------------------------
// Bloom WiSARD H3 discriminator package
// Shared constants, payload structs, operation and state codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bwh_pkg;

  localparam int RAM_COUNT        = 64;
  localparam int RAM_W            = 6;
  localparam int TUPLE_BITS       = 16;
  localparam int KEY_COUNT        = 16;
  localparam int KEY_IDX_W        = $clog2(KEY_COUNT);
  localparam int KEY_W            = 64;
  localparam int MAX_ADDRESS_BITS = 10;
  localparam int NUM_CLASSES      = 16;
  localparam int CLASS_W          = 4;
  localparam int SLICE_WIDTH      = 16;
  localparam int MAX_SLICES       = 4;
  localparam int SLICE_IDX_W      = $clog2(MAX_SLICES);
  localparam int SCORE_W          = 7;
  localparam int FILTER_DEPTH     = RAM_COUNT << MAX_ADDRESS_BITS;
  localparam int FILTER_AW        = $clog2(FILTER_DEPTH);
  localparam int CFG_AW           = 4;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 7'd127;

  localparam logic [1:0] REG_ADDRESS_BITS = 2'd0;
  localparam logic [1:0] REG_NUM_HASHES   = 2'd1;
  localparam logic [1:0] REG_CLASS_COUNT  = 2'd2;

  typedef enum logic [1:0] {
    OP_TRAIN   = 2'd0,
    OP_PREDICT = 2'd1,
    OP_LOAD    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_RD,
    ST_UPD,
    ST_SCORE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]            operation;
    logic [RAM_W-1:0]      ram_index;
    logic [TUPLE_BITS-1:0] tuple_bits;
    logic [CLASS_W-1:0]    class_label;
    logic                  last_ram;
    logic [KEY_IDX_W-1:0]  key_index;
    logic [KEY_W-1:0]      key_value;
  } in_item_t;

  typedef struct packed {
    logic [CLASS_W-1:0] class_index;
    logic [SCORE_W-1:0] score;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic                  we;
    logic [KEY_IDX_W-1:0]  widx;
    logic [KEY_W-1:0]      wdata;
    logic                  start;
    logic [TUPLE_BITS-1:0] tuple_bits;
  } key_req_t;

  typedef struct packed {
    logic                   re;
    logic                   we;
    logic [FILTER_AW-1:0]   addr;
    logic [NUM_CLASSES-1:0] wdata;
  } filt_req_t;

endpackage

// ----- src/bloom_wisard_h3_discriminator.sv -----
// ---------------------------------------------------------------------------
// Bloom WiSARD H3 discriminator
// Weightless classifier with H3-hashed Bloom filters, one per RAM tuple.
// ---------------------------------------------------------------------------
// After reset the filter store is swept to zero, one entry per cycle, and
// busy stays high until the sweep ends. A train or predict item first builds
// its H3 hash one key per cycle through the single key memory port, then
// for each hash slice reads the filter store (ST_RD) and does the write or
// AND (ST_UPD); a predict item then passes through ST_SCORE and, when it
// closes a sample, emits one result per configured class. Results appear on
// consecutive cycles with out_valid and cannot be held off by the receiver.
`timescale 1ns / 1ps
`include "bloom_wisard_h3_discriminator_macros.svh"

module bloom_wisard_h3_discriminator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  bwh_pkg::in_item_t                    in_item,
  output logic                                 out_valid,
  output bwh_pkg::out_item_t                   out_item,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bwh_pkg::CFG_AW-1:0]           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import bwh_pkg::*;

  state_t state_r, state_nxt;

  logic [3:0] addr_bits_r;
  logic [2:0] num_hashes_r;
  logic [4:0] class_count_r;

  logic [3:0] eff_ab;
  logic [2:0] eff_nh;
  logic [4:0] eff_nc;

  logic [1:0]             op_r;
  logic [RAM_W-1:0]       ram_r;
  logic [CLASS_W-1:0]     label_r;
  logic                   last_r;
  logic [SLICE_IDX_W-1:0] k_r;
  logic [NUM_CLASSES-1:0] hit_r;
  logic [CLASS_W-1:0]     cls_r;
  logic [SCORE_W-1:0]     score_r [NUM_CLASSES];

  logic accept;
  logic label_ok;
  logic ram_ok;
  logic slice_last;
  logic cls_last;

  logic [KEY_W-1:0]            hash_w;
  logic                        hash_done;
  logic [SLICE_WIDTH-1:0]      slice_w;
  logic [MAX_ADDRESS_BITS-1:0] addr_mask;
  logic [NUM_CLASSES-1:0]      rd_data;
  logic                        clr_busy;

  key_req_t  k_req;
  filt_req_t f_req;

  assign accept = start && !busy;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_bits_r   <= 4'd10;
      num_hashes_r  <= 3'd2;
      class_count_r <= 5'd10;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_ADDRESS_BITS: addr_bits_r   <= pwdata[3:0];
        REG_NUM_HASHES:   num_hashes_r  <= pwdata[2:0];
        REG_CLASS_COUNT:  class_count_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ADDRESS_BITS: prdata = {28'd0, addr_bits_r};
      REG_NUM_HASHES:   prdata = {29'd0, num_hashes_r};
      REG_CLASS_COUNT:  prdata = {27'd0, class_count_r};
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (addr_bits_r == 4'd0) begin
      eff_ab = 4'd1;
    end else if (addr_bits_r > 4'(MAX_ADDRESS_BITS)) begin
      eff_ab = 4'(MAX_ADDRESS_BITS);
    end else begin
      eff_ab = addr_bits_r;
    end
    if (num_hashes_r == 3'd0) begin
      eff_nh = 3'd1;
    end else if (num_hashes_r > 3'(MAX_SLICES)) begin
      eff_nh = 3'(MAX_SLICES);
    end else begin
      eff_nh = num_hashes_r;
    end
    if (class_count_r == 5'd0) begin
      eff_nc = 5'd1;
    end else if (class_count_r > 5'(NUM_CLASSES)) begin
      eff_nc = 5'(NUM_CLASSES);
    end else begin
      eff_nc = class_count_r;
    end
  end

  assign label_ok   = {1'b0, in_item.class_label} < eff_nc;
  assign ram_ok     = int'(in_item.ram_index) < RAM_COUNT;
  assign slice_last = {1'b0, k_r} == (eff_nh - 3'd1);
  assign cls_last   = {1'b0, cls_r} == (eff_nc - 5'd1);

  assign addr_mask = ~({MAX_ADDRESS_BITS{1'b1}} << eff_ab);
  assign slice_w   = hash_w[{k_r, 4'b0000} +: SLICE_WIDTH];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (!clr_busy) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_item.operation)
            OP_TRAIN: begin
              if (label_ok && ram_ok) state_nxt = ST_HASH;
            end
            OP_PREDICT: begin
              if (ram_ok) begin
                state_nxt = ST_HASH;
              end else if (in_item.last_ram) begin
                state_nxt = ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_HASH: begin
        if (hash_done) state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (!slice_last) begin
          state_nxt = ST_RD;
        end else if (op_r == OP_TRAIN) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SCORE;
        end
      end
      ST_SCORE: begin
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (cls_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = state_r != ST_IDLE;
    out_valid = state_r == ST_EMIT;

    k_req.we         = accept && (in_item.operation == OP_LOAD);
    k_req.widx       = in_item.key_index;
    k_req.wdata      = in_item.key_value;
    k_req.start      = (state_r == ST_IDLE) && (state_nxt == ST_HASH);
    k_req.tuple_bits = in_item.tuple_bits;

    f_req.re    = state_r == ST_RD;
    f_req.we    = (state_r == ST_UPD) && (op_r == OP_TRAIN);
    f_req.addr  = {ram_r, slice_w[MAX_ADDRESS_BITS-1:0] & addr_mask};
    f_req.wdata = rd_data | (NUM_CLASSES'(1) << label_r);

    out_item.class_index = cls_r;
    out_item.score       = score_r[cls_r];
    out_item.last        = cls_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_item.operation;
      ram_r   <= in_item.ram_index;
      label_r <= in_item.class_label;
      last_r  <= in_item.last_ram;
      k_r     <= '0;
      hit_r   <= '1;
      cls_r   <= '0;
    end else begin
      if (state_r == ST_UPD) begin
        hit_r <= hit_r & rd_data;
        k_r   <= k_r + 1'b1;
      end
      if (state_r == ST_EMIT) begin
        cls_r <= cls_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        score_r[c] <= '0;
      end
    end else if (state_r == ST_SCORE) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (hit_r[c] && (5'(c) < eff_nc) && (score_r[c] != SCORE_MAX)) begin
          score_r[c] <= score_r[c] + 1'b1;
        end
      end
    end else if ((state_r == ST_EMIT) && cls_last) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        score_r[c] <= '0;
      end
    end
  end

  bwh_keys u_keys (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (k_req),
    .hash  (hash_w),
    .done  (hash_done)
  );

  bwh_filter u_filter (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (f_req),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  `BWH_ASSERT_NEXT(a_emit_stops, clk, rst_n, out_valid && out_item.last, !out_valid)
  `BWH_ASSERT_NEXT(a_emit_runs, clk, rst_n, out_valid && !out_item.last, out_valid)
  `BWH_ASSERT_IMPL(a_filter_busy, clk, rst_n, f_req.we || f_req.re, busy && !clr_busy)
  `BWH_ASSERT_IMPL(a_result_busy, clk, rst_n, out_valid, busy)

endmodule

// ----- src/bwh_keys.sv -----
// ---------------------------------------------------------------------------
// H3 key store and hash accumulator
// Holds the hash keys and XORs the selected ones, one key per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bwh_keys (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bwh_pkg::key_req_t          req,
  output logic [bwh_pkg::KEY_W-1:0]  hash,
  output logic                       done
);
  import bwh_pkg::*;

  logic [KEY_W-1:0]      key_mem [KEY_COUNT];
  logic [KEY_W-1:0]      rd_r;
  logic [TUPLE_BITS-1:0] tuple_r;
  logic [KEY_IDX_W-1:0]  cnt_r;
  logic                  run_r;
  logic                  vld_d_r;
  logic                  fin_d_r;
  logic                  sel_d_r;
  logic [KEY_W-1:0]      acc_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      key_mem[req.widx] <= req.wdata;
    end
    rd_r <= key_mem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      vld_d_r <= 1'b0;
      fin_d_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      vld_d_r <= run_r;
      fin_d_r <= run_r && (cnt_r == KEY_IDX_W'(KEY_COUNT - 1));
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == KEY_IDX_W'(KEY_COUNT - 1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sel_d_r <= tuple_r[cnt_r];
    if (req.start) begin
      tuple_r <= req.tuple_bits;
      acc_r   <= '0;
    end else if (vld_d_r && sel_d_r) begin
      acc_r <= acc_r ^ rd_r;
    end
  end

  assign hash = acc_r;
  assign done = vld_d_r && fin_d_r;

endmodule

// ----- src/bwh_filter.sv -----
// ---------------------------------------------------------------------------
// Bloom filter store
// One class-bit word per RAM and address, cleared by a sweep after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bwh_filter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bwh_pkg::filt_req_t               req,
  output logic [bwh_pkg::NUM_CLASSES-1:0]  rd_data,
  output logic                             clr_busy
);
  import bwh_pkg::*;

  logic [NUM_CLASSES-1:0] mem [FILTER_DEPTH];
  logic [NUM_CLASSES-1:0] rd_r;
  logic [FILTER_AW-1:0]   clr_cnt_r;
  logic                   clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == FILTER_AW'(FILTER_DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rd_r <= mem[req.addr];
    end
  end

  assign rd_data  = rd_r;
  assign clr_busy = clr_r;

endmodule
